[rtl/sida_pkg.sv]
// Shared constants and control types for the signed integer to decimal text block.
// It depends on nothing. The controller, the datapath and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for any VALUE_WIDTH-bit magnitude (1233/4096 ~ log10(2)).
    localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new value and clear the digit register
        logic shift;     // one shift-and-adjust step
        logic idx_dec;   // step the digit pointer down by one
        logic sign_sel;  // the output shows the minus sign
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic neg;
        logic digit_zero;
        logic idx_zero;
    } sts_t;

endpackage

`default_nettype wire

[rtl/sida_dpath.sv]
// Datapath: magnitude register, packed decimal digit register and digit pointer.
// It depends on sida_pkg and follows commands from sida_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sida_dpath (
    input  wire                                  clk,
    input  wire logic signed [sida_pkg::VALUE_WIDTH-1:0] value,
    input  wire sida_pkg::cmd_t                  cmd,
    output sida_pkg::sts_t                       sts,
    output logic [7:0]                           char_code,
    output logic                                 last_char
);
    import sida_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] ONE     = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [IDX_W-1:0]       IDX_TOP = IDX_W'(NUM_DIGITS - 1);

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             cur_digit;

    assign raw = value;

    // Every digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            neg_next = raw[VALUE_WIDTH-1];
            bin_next = raw[VALUE_WIDTH-1] ? (~raw + ONE) : raw;
            bcd_next = '0;
            idx_next = IDX_TOP;
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        idx_reg <= idx_next;
    end

    assign cur_digit      = bcd_reg[idx_reg*4 +: 4];
    assign sts.neg        = neg_reg;
    assign sts.digit_zero = (cur_digit == 4'd0);
    assign sts.idx_zero   = (idx_reg == '0);

    assign char_code = cmd.sign_sel ? CH_MINUS : (CH_ZERO + {4'b0000, cur_digit});
    assign last_char = !cmd.sign_sel && (idx_reg == '0);

endmodule

`default_nettype wire

[rtl/sida_ctrl.sv]
// Controller: sequences conversion steps, the leading zero scan and character output.
// It depends on sida_pkg and drives sida_dpath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module sida_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  wire sida_pkg::sts_t  sts,
    output sida_pkg::cmd_t       cmd
);
    import sida_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_SIGN,
        S_DIGIT
    } state_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             stall_reg, valid_reg, sign_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.load     = 1'b0;
        cmd.shift    = 1'b0;
        cmd.idx_dec  = 1'b0;
        cmd.sign_sel = sign_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Walk down past leading zeros; the lowest digit is always shown.
                if (sts.digit_zero && !sts.idx_zero)
                    cmd.idx_dec = 1'b1;
                else
                    state_next = sts.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN:
            begin
                if (!out_stall)
                    state_next = S_DIGIT;
            end
            S_DIGIT:
            begin
                if (!out_stall)
                begin
                    if (sts.idx_zero)
                        state_next = S_IDLE;
                    else
                        cmd.idx_dec = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            stall_reg <= 1'b0;
            valid_reg <= 1'b0;
            sign_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stall_reg <= (state_next != S_IDLE);
            valid_reg <= (state_next == S_SIGN) || (state_next == S_DIGIT);
            sign_reg  <= (state_next == S_SIGN);
        end
    end

    assign in_stall     = stall_reg;
    assign out_valid    = valid_reg;

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result offered while input side is open");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !out_valid))
        else $error("block not busy converting after a request");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !sign_reg && sts.idx_zero) |=> (!in_stall && !out_valid))
        else $error("block not idle after the final character");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.shift, cmd.idx_dec}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

[rtl/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal text converter, one character per result request.
// Sequence: accept, VALUE_WIDTH shift-and-add-3 steps in the datapath, then a leading
// zero scan before the first character.
// Throughput: one character per cycle while the sink does not stall; a new value is
// accepted only once the last character of the previous one has been taken.
// Reset: rst_n asynchronously returns the controller to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire logic signed [sida_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [7:0]                           char_code,
    output logic                                 last_char
);
    import sida_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sida_dpath u_dpath (
        .clk       (clk),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for signed_int_to_decimal_ascii: drives signed integers and
// checks every emitted character against text predicted inside this bench.
// It depends on sida_pkg for the value width and the character codes.
`timescale 1ns / 1ps

module tb;

    import sida_pkg::*;

    localparam int VW = VALUE_WIDTH;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [VW-1:0] value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           char_code;
    logic                 last_char;

    text_char_t pending_chars[$];
    int         mismatch_count = 0;
    int         values_sent = 0;
    int         negatives_sent = 0;
    int         chars_checked = 0;
    int         hold_off_cycles = 0;
    bit         idle_on = 1'b1;

    signed_int_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    always #5 clk = ~clk;

    // Queues the decimal text of one number, most significant digit first.
    function automatic void predict_decimal_text(input logic signed [VW-1:0] v);
        logic [VW-1:0] raw;
        logic [VW-1:0] mag;
        logic [3:0]    digits [0:19];
        int            nd;
        text_char_t    ch;
        raw = v;
        // The magnitude stays unsigned so the most negative value survives negation.
        mag = raw[VW-1] ? (~raw + 1'b1) : raw;
        nd = 0;
        do
        begin
            digits[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end
        while (mag != 0);
        if (raw[VW-1])
        begin
            ch.code = CH_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            ch.code = CH_ZERO + 8'(digits[i]);
            ch.last = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    function automatic logic signed [VW-1:0] random_value();
        longint mag;
        longint pow;
        int     sel;
        int     k;
        sel = $urandom_range(0, 9);
        mag = 0;
        pow = 1;
        case (sel)
            4, 5: mag = $urandom_range(0, 2000);
            6:
            begin
                k = $urandom_range(0, 9);
                repeat (k) pow = pow * 10;
                mag = pow * ((k == 9) ? $urandom_range(1, 2) : $urandom_range(1, 9));
            end
            7:
            begin
                // Dense runs of zero digits inside the number.
                repeat ($urandom_range(1, 9))
                    mag = mag * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
            end
            8:
            begin
                if ($urandom_range(0, 1))
                    return {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
                return {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
            end
            9:
            begin
                repeat ($urandom_range(1, 9)) pow = pow * 10;
                mag = pow - $urandom_range(0, 1);
            end
            default: return VW'($urandom);
        endcase
        if ($urandom_range(0, 1))
            mag = -mag;
        return VW'(mag);
    endfunction

    // Offers one request and returns once it is accepted; valid stays high on a zero gap.
    task automatic send_value(input logic signed [VW-1:0] v);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        predict_decimal_text(v);
        values_sent++;
        if (v < 0)
            negatives_sent++;
    endtask

    task automatic test_corner_values();
        longint corners [] = '{0, 1, -1, 9, -9, 10, -10, 100, 105, -105, 10203, -100000,
                               999999999, -999999999, 1000000000, 1000000001, -2000000000,
                               2147483647, 2147483640, -2147483647, -2147483648};
        foreach (corners[i])
            send_value(VW'(corners[i]));
    endtask

    task automatic test_random_values();
        repeat (400) send_value(random_value());
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (30) send_value(random_value());
        idle_on = 1'b1;
    endtask

    // The sink holds off for a long stretch while requests keep coming, so the
    // block must stall its input until the sink drains.
    task automatic test_sink_backpressure();
        idle_on = 1'b0;
        hold_off_cycles = 300;
        repeat (12) send_value(random_value());
        idle_on = 1'b1;
    endtask

    initial
    begin : result_sink
        int wait_cycles;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                wait_cycles = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
            begin
                wait_cycles = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin : text_checker
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character 0x%02h with no text pending", char_code);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (char_code !== want.code)
                begin
                    $error("char_code: expected 0x%02h, got 0x%02h", want.code, char_code);
                    mismatch_count++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %0b, got %0b", want.last, last_char);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("signed_int_to_decimal_ascii regression: fail");
        $finish;
    end

    initial
    begin : main_sequence
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_corner_values();
        test_random_values();
        test_back_to_back();
        test_sink_backpressure();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        $display("Sent %0d values (%0d negative), including both extremes and zero.",
                 values_sent, negatives_sent);
        $display("Checked %0d characters under random idling and a long sink hold-off.",
                 chars_checked);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("signed_int_to_decimal_ascii regression: pass");
        else
            $display("signed_int_to_decimal_ascii regression: fail");
        $finish;
    end

endmodule
